/* rtl/core/rhc_pkg.sv */
// shared constants and types for the routing histogram counter
`default_nettype none

package rhc_pkg;

    localparam int MODE_W      = 2;
    localparam int LAYER_W     = 6;
    localparam int ID_W        = 9;
    localparam int TOTAL_W     = 40;
    localparam int COUNT_OUT_W = 32;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 72;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int LIMIT_L_W   = 7;

    localparam logic [MODE_W-1:0] MODE_RECORD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_ENABLE  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LAYERS  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_EXPERTS = 2'd2;

    typedef struct packed {
        logic rd;
        logic upd;
        logic clr;
        logic clr_tot;
    } t_store_cmd;

endpackage

`default_nettype wire

/* rtl/core/rhc_store.sv */
// count and total memories with saturating read-modify-write and clear writes
`default_nettype none

module rhc_store #(
    parameter int DEPTH      = 16384,
    parameter int LAYERS     = 64,
    parameter int AW         = 14,
    parameter int LW         = 6,
    parameter int COUNT_BITS = 32
) (
    input  wire                             i_clk,
    input  rhc_pkg::t_store_cmd             i_cmd,
    input  wire  [AW-1:0]                   i_cnt_addr,
    input  wire  [LW-1:0]                   i_tot_addr,
    output logic [COUNT_BITS-1:0]           o_cnt_q,
    output logic [rhc_pkg::TOTAL_W-1:0]     o_tot_q,
    output logic [COUNT_BITS-1:0]           o_cnt_inc,
    output logic [rhc_pkg::TOTAL_W-1:0]     o_tot_inc
);

    logic [COUNT_BITS-1:0]       r_cnt_mem [DEPTH];
    logic [rhc_pkg::TOTAL_W-1:0] r_tot_mem [LAYERS];
    logic [COUNT_BITS-1:0]       r_cnt_q;
    logic [rhc_pkg::TOTAL_W-1:0] r_tot_q;

    // saturating increments of the entries read in the previous cycle
    assign o_cnt_inc = (&r_cnt_q) ? r_cnt_q : r_cnt_q + COUNT_BITS'(1);
    assign o_tot_inc = (&r_tot_q) ? r_tot_q : r_tot_q + rhc_pkg::TOTAL_W'(1);
    assign o_cnt_q   = r_cnt_q;
    assign o_tot_q   = r_tot_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_cnt_q <= r_cnt_mem[i_cnt_addr];
            r_tot_q <= r_tot_mem[i_tot_addr];
        end
        if (i_cmd.upd) begin
            r_cnt_mem[i_cnt_addr] <= o_cnt_inc;
            r_tot_mem[i_tot_addr] <= o_tot_inc;
        end else if (i_cmd.clr) begin
            r_cnt_mem[i_cnt_addr] <= '0;
            if (i_cmd.clr_tot) begin
                r_tot_mem[i_tot_addr] <= '0;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/routing_histogram_counter_unit.sv */
// top level of the per-layer expert routing histogram counter
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid / tready        tdata: layer, expert; tuser: mode; tlast: batch_end
//  m_axis    out  tvalid / tready        tdata: expert_count, layer sum; tuser: accepted;
//                                        tlast: batch_done
//  cfg       in   we (no wait)           addr: register index, wdata: value
//
//  record, read and unused mode: accept and memory read, update and write back of an
//  accepted record, move to the output register once that register is free
//  clear: one count entry and, for the first MAX_LAYERS, one total entry zeroed per cycle
//  after reset the same sweep runs with tready low
//  a new item is taken while the previous result still waits in the output register
`default_nettype none

module routing_histogram_counter_unit #(
    parameter int MAX_LAYERS  = 64,
    parameter int MAX_EXPERTS = 256,
    parameter int COUNT_BITS  = 32
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [5:0] layer, [14:6] expert, [15] zero
    input  wire  [rhc_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // [1:0] mode
    input  wire  [rhc_pkg::MODE_W-1:0]          i_s_axis_tuser,
    input  wire                                 i_s_axis_tlast,
    output logic                                o_m_axis_tvalid,
    input  wire                                 i_m_axis_tready,
    // [31:0] expert_count, [71:32] layer sum
    output logic [rhc_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    // [0] accepted
    output logic                                o_m_axis_tuser,
    output logic                                o_m_axis_tlast,
    input  wire                                 i_cfg_we,
    input  wire  [rhc_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  wire  [rhc_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    localparam int DEPTH = MAX_LAYERS * MAX_EXPERTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RMW,
        S_SEND
    } t_state;

    t_state                         r_state;
    logic                           r_enable;
    logic [rhc_pkg::LIMIT_L_W-1:0]  r_layers;
    logic [rhc_pkg::CFG_DATA_W-1:0] r_experts;
    logic [AW-1:0]                  r_clr_idx;
    logic                           r_clr_item;
    logic [AW-1:0]                  r_addr;
    logic [LW-1:0]                  r_tot_addr;
    logic                           r_rec;
    logic                           r_pair_ok;
    logic                           r_layer_ok;
    logic                           r_batch;
    logic [rhc_pkg::COUNT_OUT_W-1:0] r_p_cnt;
    logic [rhc_pkg::TOTAL_W-1:0]    r_p_tot;
    logic                           r_p_acc;
    logic                           r_p_batch;
    logic                           r_o_valid;
    logic [rhc_pkg::COUNT_OUT_W-1:0] r_o_cnt;
    logic [rhc_pkg::TOTAL_W-1:0]    r_o_tot;
    logic                           r_o_acc;
    logic                           r_o_last;

    logic [rhc_pkg::MODE_W-1:0]     in_mode;
    logic [rhc_pkg::LAYER_W-1:0]    in_layer;
    logic [rhc_pkg::ID_W-1:0]       in_id;
    logic                           in_layer_ok;
    logic                           in_pair_ok;
    logic                           in_rec;
    logic [AW-1:0]                  in_addr;
    logic                           s_accept;
    logic                           out_free;
    logic                           clr_last;

    rhc_pkg::t_store_cmd            store_cmd;
    logic [AW-1:0]                  cnt_addr;
    logic [LW-1:0]                  tot_addr;
    logic [COUNT_BITS-1:0]          cnt_q;
    logic [rhc_pkg::TOTAL_W-1:0]    tot_q;
    logic [COUNT_BITS-1:0]          cnt_inc;
    logic [rhc_pkg::TOTAL_W-1:0]    tot_inc;
    logic [63:0]                    n_cnt_wide;
    logic [rhc_pkg::COUNT_OUT_W-1:0] n_cnt;
    logic [rhc_pkg::TOTAL_W-1:0]    n_tot;

    assign in_mode  = i_s_axis_tuser;
    assign in_layer = i_s_axis_tdata[5:0];
    assign in_id    = i_s_axis_tdata[14:6];

    assign in_layer_ok = 32'(in_layer) < 32'(MAX_LAYERS);
    assign in_pair_ok  = in_layer_ok && !in_id[8] && (32'(in_id[7:0]) < 32'(MAX_EXPERTS));
    assign in_rec      = (in_mode == rhc_pkg::MODE_RECORD) && r_enable && in_pair_ok
                         && ({1'b0, in_layer} < r_layers)
                         && ({1'b0, in_id[7:0]} < r_experts);
    assign in_addr     = AW'(int'(in_layer) * MAX_EXPERTS + int'(in_id[7:0]));

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_o_valid || i_m_axis_tready;
    assign clr_last        = (r_clr_idx == AW'(DEPTH - 1));

    always_comb begin
        store_cmd.rd      = s_accept;
        store_cmd.upd     = (r_state == S_RMW) && r_rec;
        store_cmd.clr     = (r_state == S_CLEAR);
        store_cmd.clr_tot = 32'(r_clr_idx) < 32'(MAX_LAYERS);
        unique case (r_state)
            S_CLEAR: begin
                cnt_addr = r_clr_idx;
                tot_addr = LW'(r_clr_idx);
            end
            S_IDLE: begin
                cnt_addr = in_addr;
                tot_addr = LW'(in_layer);
            end
            default: begin
                cnt_addr = r_addr;
                tot_addr = r_tot_addr;
            end
        endcase
    end

    rhc_store #(
        .DEPTH      (DEPTH),
        .LAYERS     (MAX_LAYERS),
        .AW         (AW),
        .LW         (LW),
        .COUNT_BITS (COUNT_BITS)
    ) u_store (
        .i_clk      (i_clk),
        .i_cmd      (store_cmd),
        .i_cnt_addr (cnt_addr),
        .i_tot_addr (tot_addr),
        .o_cnt_q    (cnt_q),
        .o_tot_q    (tot_q),
        .o_cnt_inc  (cnt_inc),
        .o_tot_inc  (tot_inc)
    );

    // result fields after the update, count clipped to the output width
    always_comb begin
        n_cnt_wide = r_pair_ok ? 64'(r_rec ? cnt_inc : cnt_q) : 64'd0;
        n_cnt      = (|n_cnt_wide[63:32]) ? '1 : n_cnt_wide[31:0];
        n_tot      = r_layer_ok ? (r_rec ? tot_inc : tot_q) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_enable   <= 1'b0;
            r_layers   <= '0;
            r_experts  <= '0;
            r_clr_idx  <= '0;
            r_clr_item <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    rhc_pkg::CFG_ENABLE:  r_enable  <= i_cfg_wdata[0];
                    rhc_pkg::CFG_LAYERS:  r_layers  <= i_cfg_wdata[rhc_pkg::LIMIT_L_W-1:0];
                    rhc_pkg::CFG_EXPERTS: r_experts <= i_cfg_wdata;
                    default: ;
                endcase
            end

            if (r_o_valid && i_m_axis_tready && (r_state != S_SEND)) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    if (clr_last) begin
                        r_clr_idx  <= '0;
                        r_clr_item <= 1'b0;
                        r_state    <= r_clr_item ? S_SEND : S_IDLE;
                    end else begin
                        r_clr_idx <= r_clr_idx + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (s_accept) begin
                        r_addr     <= in_addr;
                        r_tot_addr <= LW'(in_layer);
                        r_rec      <= in_rec;
                        r_pair_ok  <= in_pair_ok;
                        r_layer_ok <= in_layer_ok;
                        r_batch    <= i_s_axis_tlast;
                        if (in_mode == rhc_pkg::MODE_CLEAR) begin
                            r_p_cnt    <= '0;
                            r_p_tot    <= '0;
                            r_p_acc    <= 1'b0;
                            r_p_batch  <= i_s_axis_tlast;
                            r_clr_item <= 1'b1;
                            r_state    <= S_CLEAR;
                        end else begin
                            r_state <= S_RMW;
                        end
                    end
                end
                S_RMW: begin
                    r_p_cnt   <= n_cnt;
                    r_p_tot   <= n_tot;
                    r_p_acc   <= r_rec;
                    r_p_batch <= r_batch;
                    r_state   <= S_SEND;
                end
                S_SEND: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_cnt   <= r_p_cnt;
                        r_o_tot   <= r_p_tot;
                        r_o_acc   <= r_p_acc;
                        r_o_last  <= r_p_batch;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {r_o_tot, r_o_cnt};
    assign o_m_axis_tuser  = r_o_acc;
    assign o_m_axis_tlast  = r_o_last;

    a_acc_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_acc) |-> (r_o_tot != '0))
        else $error("accepted record reported with zero layer total");

    a_acc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_acc) |-> (r_o_cnt != '0))
        else $error("accepted record reported with zero expert count");

    a_upd_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        store_cmd.upd |-> $past(store_cmd.rd))
        else $error("store write back without a read in the previous cycle");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_CLEAR && r_state == S_CLEAR) |-> !$past(s_accept))
        else $error("item taken during the clear sweep");

endmodule

`default_nettype wire

/* tb/routing_histogram_counter_unit_tb.sv */
// self-checking stream testbench for the routing histogram counter unit
module routing_histogram_counter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [rhc_pkg::MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [rhc_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam int N_LAYERS    = 64;
    localparam int N_EXPERTS   = 256;
    localparam int CNT_BITS    = 32;
    localparam int CYCLE_LIMIT = 1000000;

    localparam logic [CNT_BITS-1:0]         CNT_SAT = '1;
    localparam logic [rhc_pkg::TOTAL_W-1:0] TOT_SAT = '1;

    typedef struct packed {
        logic [rhc_pkg::MODE_W-1:0]  mode;
        logic [rhc_pkg::LAYER_W-1:0] layer;
        logic [rhc_pkg::ID_W-1:0]    id;
        logic                        last;
    } t_route_item;

    typedef struct packed {
        logic [rhc_pkg::COUNT_OUT_W-1:0] count;
        logic [rhc_pkg::TOTAL_W-1:0]     total;
        logic                            acc;
        logic                            done;
    } t_hist_result;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    logic                               s_valid = 1'b0;
    logic [rhc_pkg::IN_TDATA_W-1:0]     s_data  = '0;
    logic [rhc_pkg::MODE_W-1:0]         s_user  = '0;
    logic                               s_last  = 1'b0;
    wire                                s_ready;
    wire                                m_valid;
    wire [rhc_pkg::OUT_TDATA_W-1:0]     m_data;
    wire                                m_user;
    wire                                m_last;
    logic                               m_ready = 1'b0;
    logic                               cfg_we    = 1'b0;
    logic [rhc_pkg::CFG_ADDR_W-1:0]     cfg_addr  = '0;
    logic [rhc_pkg::CFG_DATA_W-1:0]     cfg_wdata = '0;

    // shadow registers and store
    logic                               sh_enable = 1'b0;
    logic [rhc_pkg::LIMIT_L_W-1:0]      sh_layers = '0;
    logic [rhc_pkg::ID_W-1:0]           sh_experts = '0;
    logic [CNT_BITS-1:0]                hist_counts [N_LAYERS][N_EXPERTS];
    logic [rhc_pkg::TOTAL_W-1:0]        layer_sums [N_LAYERS];

    t_route_item  pending_routes [$];
    t_hist_result hist_expected [$];
    t_route_item  cur_route;

    bit in_xfer  = 1'b0;
    bit out_xfer = 1'b0;
    int tx_gap   = 0;
    int tx_run   = 0;
    int rx_wait  = 0;
    int rx_run   = 0;
    int n_done   = 0;
    int errors   = 0;
    int cycles   = 0;
    int clears_left = 3;

    routing_histogram_counter_unit #(
        .MAX_LAYERS (N_LAYERS),
        .MAX_EXPERTS(N_EXPERTS),
        .COUNT_BITS (CNT_BITS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),
        .i_s_axis_tuser (s_user),
        .i_s_axis_tlast (s_last),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data),
        .o_m_axis_tuser (m_user),
        .o_m_axis_tlast (m_last),
        .i_cfg_we       (cfg_we),
        .i_cfg_addr     (cfg_addr),
        .i_cfg_wdata    (cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int idle_draw(inout int run);
        if (run > 0) begin
            run--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            run = 15;
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    task automatic predict_route(input t_route_item it);
        t_hist_result r;
        logic         neg;
        int           lay_lim;
        int           exp_lim;
        r      = '0;
        r.done = it.last;
        if (it.mode == rhc_pkg::MODE_CLEAR) begin
            for (int l = 0; l < N_LAYERS; l++) begin
                layer_sums[l] = '0;
                for (int e = 0; e < N_EXPERTS; e++) hist_counts[l][e] = '0;
            end
        end else begin
            neg     = it.id[rhc_pkg::ID_W-1];
            lay_lim = (sh_layers < N_LAYERS) ? sh_layers : N_LAYERS;
            exp_lim = (sh_experts < N_EXPERTS) ? sh_experts : N_EXPERTS;
            if (it.mode == rhc_pkg::MODE_RECORD && sh_enable && it.layer < lay_lim && !neg
                && it.id < exp_lim) begin
                if (hist_counts[it.layer][it.id[7:0]] != CNT_SAT)
                    hist_counts[it.layer][it.id[7:0]]++;
                if (layer_sums[it.layer] != TOT_SAT)
                    layer_sums[it.layer]++;
                r.acc = 1'b1;
            end
            if (!neg) r.count = hist_counts[it.layer][it.id[7:0]];
            r.total = layer_sums[it.layer];
        end
        hist_expected.push_back(r);
    endtask

    task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t mismatch %s expected %h actual %h", $time, what, want, got);
        end
    endtask

    // input side
    always @(posedge i_clk) begin
        in_xfer = rst_n && s_valid && s_ready;
        if (in_xfer) predict_route(cur_route);
    end

    always @(negedge i_clk) begin
        if (!rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_xfer) begin
            if (in_xfer) tx_gap = idle_draw(tx_run);
            if (tx_gap > 0) begin
                tx_gap--;
                s_valid <= 1'b0;
            end else if (pending_routes.size() != 0) begin
                cur_route = pending_routes.pop_front();
                s_valid <= 1'b1;
                s_data  <= {1'b0, cur_route.id, cur_route.layer};
                s_user  <= cur_route.mode;
                s_last  <= cur_route.last;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // output side
    always @(posedge i_clk) begin : result_check
        t_hist_result want;
        out_xfer = rst_n && m_valid && m_ready;
        if (out_xfer) begin
            n_done++;
            if (hist_expected.size() == 0) begin
                errors++;
                $display("%0t unexpected transfer expected none actual %h last %b",
                         $time, m_data, m_last);
            end else begin
                want = hist_expected.pop_front();
                check_field("expert_count", 64'(want.count),
                            64'(m_data[rhc_pkg::COUNT_OUT_W-1:0]));
                check_field("layer_sum", 64'(want.total),
                            64'(m_data[rhc_pkg::OUT_TDATA_W-1:rhc_pkg::COUNT_OUT_W]));
                check_field("accepted", 64'(want.acc), 64'(m_user));
                check_field("batch_done", 64'(want.done), 64'(m_last));
            end
        end
    end

    always @(negedge i_clk) begin
        if (out_xfer) begin
            // long hold so the block backs up and stalls its input
            if (n_done == 80 || n_done == 500) rx_wait = 400;
            else rx_wait = idle_draw(rx_run);
        end
        if (rx_wait > 0) begin
            rx_wait--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic cfg_write(input logic [rhc_pkg::CFG_ADDR_W-1:0] idx, input int val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= rhc_pkg::CFG_DATA_W'(val);
        case (idx)
            rhc_pkg::CFG_ENABLE:  sh_enable  = val[0];
            rhc_pkg::CFG_LAYERS:  sh_layers  = val[rhc_pkg::LIMIT_L_W-1:0];
            rhc_pkg::CFG_EXPERTS: sh_experts = val[rhc_pkg::ID_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input int en, input int lay, input int exps);
        cfg_write(rhc_pkg::CFG_ENABLE, en);
        cfg_write(rhc_pkg::CFG_LAYERS, lay);
        cfg_write(rhc_pkg::CFG_EXPERTS, exps);
    endtask

    task automatic wait_idle();
        while (pending_routes.size() != 0 || s_valid || hist_expected.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic add_route(input logic [rhc_pkg::MODE_W-1:0] mode, input int layer,
                             input int id, input bit last);
        t_route_item it;
        it.mode  = mode;
        it.layer = rhc_pkg::LAYER_W'(layer);
        it.id    = rhc_pkg::ID_W'(id);
        it.last  = last;
        pending_routes.push_back(it);
    endtask

    task automatic queue_random(input int n);
        t_route_item it;
        int          lay_span;
        int          exp_span;
        int          r;
        lay_span = (sh_layers < N_LAYERS) ? sh_layers : N_LAYERS;
        exp_span = (sh_experts < N_EXPERTS) ? sh_experts : N_EXPERTS;
        if (lay_span == 0) lay_span = N_LAYERS;
        if (exp_span == 0) exp_span = N_EXPERTS;
        repeat (n) begin
            r        = $urandom_range(0, 99);
            it.layer = rhc_pkg::LAYER_W'($urandom_range(0, N_LAYERS - 1));
            it.id    = rhc_pkg::ID_W'($urandom_range(0, 511));
            it.last  = ($urandom_range(0, 3) == 0);
            if (r < 70) begin
                it.mode = rhc_pkg::MODE_RECORD;
                if (r < 62) begin
                    it.layer = rhc_pkg::LAYER_W'($urandom_range(0, lay_span - 1));
                    it.id    = rhc_pkg::ID_W'($urandom_range(0, exp_span - 1));
                    if ($urandom_range(0, 1)) begin
                        it.layer = rhc_pkg::LAYER_W'(it.layer % 4);
                        it.id    = rhc_pkg::ID_W'(it.id % 8);
                    end
                end
            end else if (r < 88) begin
                it.mode = MODE_READ;
                if ($urandom_range(0, 1)) begin
                    it.layer = rhc_pkg::LAYER_W'(it.layer % 4);
                    it.id    = rhc_pkg::ID_W'(it.id % 8);
                end
            end else if (r < 96) begin
                it.mode = MODE_SPARE;
            end else if (r < 98 && clears_left > 0) begin
                it.mode = rhc_pkg::MODE_CLEAR;
                clears_left--;
            end else begin
                it.mode = MODE_READ;
            end
            pending_routes.push_back(it);
        end
    endtask

    initial begin
        for (int l = 0; l < N_LAYERS; l++) begin
            layer_sums[l] = '0;
            for (int e = 0; e < N_EXPERTS; e++) hist_counts[l][e] = '0;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        set_regs(1, 64, 256);
        add_route(rhc_pkg::MODE_RECORD, 0, 0, 1'b0);
        add_route(rhc_pkg::MODE_RECORD, 63, 255, 1'b1);
        add_route(rhc_pkg::MODE_RECORD, 63, 255, 1'b0);
        add_route(rhc_pkg::MODE_RECORD, 63, 'h1FF, 1'b0);    // minus one
        add_route(rhc_pkg::MODE_RECORD, 63, 'h100, 1'b1);    // most negative
        add_route(MODE_READ, 63, 255, 1'b0);
        add_route(MODE_READ, 0, 'h1FF, 1'b1);
        add_route(MODE_SPARE, 63, 255, 1'b0);
        add_route(MODE_SPARE, 42, 'h0AA, 1'b1);
        add_route(rhc_pkg::MODE_CLEAR, 42, 'h155, 1'b1);
        add_route(MODE_READ, 63, 255, 1'b0);
        add_route(rhc_pkg::MODE_RECORD, 63, 255, 1'b0);
        add_route(MODE_READ, 0, 0, 1'b1);
        wait_idle();

        set_regs(1, 5, 17);
        add_route(rhc_pkg::MODE_RECORD, 4, 16, 1'b0);
        add_route(rhc_pkg::MODE_RECORD, 5, 0, 1'b0);
        add_route(rhc_pkg::MODE_RECORD, 4, 17, 1'b1);
        add_route(MODE_READ, 4, 16, 1'b0);
        wait_idle();

        set_regs(0, 64, 256);
        add_route(rhc_pkg::MODE_RECORD, 1, 1, 1'b1);
        add_route(MODE_READ, 63, 255, 1'b0);
        wait_idle();

        // limits above the store size
        set_regs(1, 127, 511);
        add_route(rhc_pkg::MODE_RECORD, 63, 255, 1'b0);
        add_route(rhc_pkg::MODE_RECORD, 62, 'h0FF, 1'b1);
        wait_idle();

        set_regs(1, 0, 0);
        add_route(rhc_pkg::MODE_RECORD, 0, 0, 1'b0);
        add_route(MODE_READ, 0, 0, 1'b1);
        wait_idle();

        set_regs(1, 64, 256);
        queue_random(200);
        wait_idle();

        set_regs(1, $urandom_range(1, 64), $urandom_range(1, 256));
        queue_random(150);
        wait_idle();

        set_regs(0, $urandom_range(0, 127), $urandom_range(0, 511));
        queue_random(80);
        wait_idle();

        set_regs(1, 127, 511);
        queue_random(170);
        wait_idle();

        set_regs(1, $urandom_range(1, 8), $urandom_range(1, 16));
        queue_random(150);
        wait_idle();

        repeat (20) @(posedge i_clk);
        if (errors == 0 && hist_expected.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
